>>> hdl/heatmap_peak_finder_unit_defines.svh
// assertion helpers used by the peak finder datapath
`ifndef HEATMAP_PEAK_FINDER_UNIT_DEFINES_SVH
`define HEATMAP_PEAK_FINDER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define HPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define HPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hpf_pkg.sv
package hpf_pkg;

  // defaults for the top level parameters
  localparam int MAX_WIDTH_DEF   = 512;
  localparam int MAX_PEAKS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed widths and limits
  localparam int HEIGHT_LIMIT = 512;
  localparam int ROW_W        = 9;
  localparam int POS_W        = 15;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int THRESH_W     = 16;
  localparam int DIM_W        = 10;
  localparam int MIN_DIM      = 3;
  localparam int FRAC_BITS    = 6;
  localparam int ROUND_SHIFT  = FRAC_BITS + 1;

  localparam logic signed [THRESH_W-1:0] THRESH_RESET = 16'sd410;
  localparam logic [DIM_W-1:0]           DIM_RESET    = 10'd368;

  // result kinds
  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_MAP_WIDTH  = 2'd1,
    REG_MAP_HEIGHT = 2'd2
  } hpf_reg_e;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WIN,
    S_EVAL,
    S_DECIDE,
    S_DX_GO,
    S_DX_WAIT,
    S_DY_GO,
    S_DY_WAIT,
    S_PEAK_OUT,
    S_SUM_OUT
  } hpf_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic shift;
    logic eval;
    logic div_start;
    logic div_sel_y;
    logic latch_x;
    logic latch_y;
    logic load_peak;
    logic load_sum;
  } hpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic peak;
    logic zero_den;
    logic end_of_map;
    logic div_done;
    logic out_free;
  } hpf_status_t;

endpackage

>>> hdl/hpf_sample_if.sv
interface hpf_sample_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/hpf_result_if.sv
interface hpf_result_if import hpf_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [POS_W-1:0]              x_pos;
  logic [POS_W-1:0]              y_pos;
  logic signed [SAMPLE_BITS-1:0] score;
  logic [COUNT_W-1:0]            peak_count;
  logic                          zero_weight;
  logic                          last;

  modport source (output valid, output kind, output x_pos, output y_pos, output score,
                  output peak_count, output zero_weight, output last, input ready);
  modport sink   (input valid, input kind, input x_pos, input y_pos, input score,
                  input peak_count, input zero_weight, input last, output ready);
endinterface

>>> hdl/hpf_cfg_if.sv
interface hpf_cfg_if import hpf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/hpf_divider.sv
module hpf_divider import hpf_pkg::*; #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             rem_nz_o,
  output logic             done_o
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign quo_o    = num_q;
  assign rem_nz_o = rem_q != '0;
  assign done_o   = done_q;
endmodule

>>> hdl/hpf_ctrl.sv
module hpf_ctrl import hpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hpf_status_t st_i,
  output hpf_cmd_t    cmd_o
);
  hpf_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_WIN;
      end
      S_WIN: begin
        cmd_o.shift = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (st_i.peak) begin
          state_d = st_i.zero_den ? S_PEAK_OUT : S_DX_GO;
        end else begin
          state_d = st_i.end_of_map ? S_SUM_OUT : S_IDLE;
        end
      end
      S_DX_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.latch_x = 1'b1;
          state_d       = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_d         = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.latch_y = 1'b1;
          state_d       = S_PEAK_OUT;
        end
      end
      S_PEAK_OUT: begin
        if (st_i.out_free) begin
          cmd_o.load_peak = 1'b1;
          state_d         = st_i.end_of_map ? S_SUM_OUT : S_IDLE;
        end
      end
      S_SUM_OUT: begin
        if (st_i.out_free) begin
          cmd_o.load_sum = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end
endmodule

>>> hdl/hpf_datapath.sv
`include "heatmap_peak_finder_unit_defines.svh"

module hpf_datapath import hpf_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_PEAKS   = MAX_PEAKS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  hpf_cmd_t                      cmd_i,
  output hpf_status_t                   st_o,
  hpf_cfg_if.sink                       cfg_i,
  hpf_result_if.source                  res_o
);
  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int MWB   = $clog2(MAX_WIDTH + 1);
  localparam int DIMW  = ((MWB > DIM_W) ? MWB : DIM_W) + 1;
  localparam int HW    = DIM_W + 1;
  localparam int PKW   = $clog2(MAX_PEAKS + 1);
  localparam int SUMW  = SB + 3;
  localparam int DIFW  = SB + 4;
  localparam int DVW   = SB + 4;
  localparam int NW    = SB + 11;
  localparam int CMPW  = (SB > THRESH_W) ? SB : THRESH_W;
  localparam int TW    = (((NW + 1) > (DIMW + FRAC_BITS + 1)) ? (NW + 1)
                         : (DIMW + FRAC_BITS + 1)) + 1;

  // configuration registers
  logic signed [THRESH_W-1:0] thresh_q;
  logic [DIM_W-1:0]           width_q;
  logic [DIM_W-1:0]           height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_i.valid) begin
      case (hpf_reg_e'(cfg_i.index))
        REG_THRESHOLD:  thresh_q <= $signed(cfg_i.data[THRESH_W-1:0]);
        REG_MAP_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        REG_MAP_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped map size
  logic [DIMW-1:0] w_dim;
  logic [HW-1:0]   h_dim;

  always_comb begin
    if (DIMW'(width_q) < DIMW'(MIN_DIM))        w_dim = DIMW'(MIN_DIM);
    else if (DIMW'(width_q) > DIMW'(MAX_WIDTH)) w_dim = DIMW'(MAX_WIDTH);
    else                                        w_dim = DIMW'(width_q);
    if (HW'(height_q) < HW'(MIN_DIM))           h_dim = HW'(MIN_DIM);
    else if (HW'(height_q) > HW'(HEIGHT_LIMIT)) h_dim = HW'(HEIGHT_LIMIT);
    else                                        h_dim = HW'(height_q);
  end

  // position and peak counters
  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [PKW-1:0]   peaks_q;
  logic [CW-1:0]    clr_addr_q;
  logic signed [SB-1:0] sample_q;

  // line buffers: older row and newer row
  logic signed [SB-1:0] top_mem [MAX_WIDTH];
  logic signed [SB-1:0] mid_mem [MAX_WIDTH];
  logic signed [SB-1:0] top_rd_q;
  logic signed [SB-1:0] mid_rd_q;
  logic                 mem_we;
  logic [CW-1:0]        mem_waddr;
  logic signed [SB-1:0] top_wdata;
  logic signed [SB-1:0] mid_wdata;

  always_comb begin
    mem_we    = cmd_i.clear | cmd_i.shift;
    mem_waddr = cmd_i.clear ? clr_addr_q : col_q;
    top_wdata = cmd_i.clear ? '0 : mid_rd_q;
    mid_wdata = cmd_i.clear ? '0 : sample_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) top_mem[mem_waddr] <= top_wdata;
    if (cmd_i.capture) top_rd_q <= top_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mid_mem[mem_waddr] <= mid_wdata;
    if (cmd_i.capture) mid_rd_q <= mid_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) sample_q <= sample_i;
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + CW'(1);
    end
  end

  assign st_o.clear_done = clr_addr_q == CW'(MAX_WIDTH - 1);

  // 3x3 window, shifted left with the new column on the right
  logic signed [SB-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= top_rd_q;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= mid_rd_q;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= sample_q;
    end
  end

  // peak test and neighbour sums
  logic signed [SUMW-1:0] wx [9];
  logic signed [SUMW-1:0] den_c, dx_c, dy_c;
  logic                   gt_all, above, candidate, is_peak;
  logic                   col_wrap, row_wrap, end_hit;

  always_comb begin
    for (int k = 0; k < 9; k++) wx[k] = SUMW'(win_q[k]);
    gt_all = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && !(win_q[4] > win_q[k])) gt_all = 1'b0;
    end
    above     = CMPW'(win_q[4]) > CMPW'(thresh_q);
    candidate = (row_q >= ROW_W'(2)) && (col_q >= CW'(2)) && (PKW'(peaks_q) < PKW'(MAX_PEAKS));
    is_peak   = candidate && above && gt_all;
    den_c     = wx[0] + wx[1] + wx[2] + wx[3] + wx[5] + wx[6] + wx[7] + wx[8];
    dx_c      = (wx[2] + wx[5] + wx[8]) - (wx[0] + wx[3] + wx[6]);
    dy_c      = (wx[6] + wx[7] + wx[8]) - (wx[0] + wx[1] + wx[2]);
    col_wrap  = (DIMW'(col_q) + DIMW'(1)) >= w_dim;
    row_wrap  = (HW'(row_q) + HW'(1)) >= h_dim;
    end_hit   = col_wrap && row_wrap;
  end

  logic                   peak_q, zero_q, end_q;
  logic signed [SUMW-1:0] den_q, dx_q, dy_q;
  logic [CW-1:0]          cx_q;
  logic [ROW_W-1:0]       cy_q;
  logic signed [SB-1:0]   score_q;
  logic [PKW-1:0]         cnt_peak_q, cnt_sum_q;

  // judged item flags and operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      den_q      <= den_c;
      dx_q       <= dx_c;
      dy_q       <= dy_c;
      cx_q       <= col_q - CW'(1);
      cy_q       <= row_q - ROW_W'(1);
      score_q    <= win_q[4];
      cnt_peak_q <= peaks_q + PKW'(1);
      cnt_sum_q  <= peaks_q + PKW'(is_peak);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= 1'b0;
      zero_q  <= 1'b0;
      end_q   <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      peaks_q <= '0;
    end else if (cmd_i.eval) begin
      peak_q  <= is_peak;
      zero_q  <= den_c == '0;
      end_q   <= end_hit;
      peaks_q <= end_hit ? '0 : peaks_q + PKW'(is_peak);
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  assign st_o.peak       = peak_q;
  assign st_o.zero_den   = zero_q;
  assign st_o.end_of_map = end_q;

  // divider operands: round(64*d/den) = floor((128*d + den) / (2*den)), den made positive
  logic                   den_neg;
  logic signed [DVW-1:0]  den_w, den_abs;
  logic [DVW-1:0]         divisor;
  logic signed [DIFW-1:0] d_ext, d_adj;
  logic signed [NW-1:0]   n_c;
  logic                   n_neg;
  logic [NW-1:0]          n_mag;

  always_comb begin
    den_neg = den_q[SUMW-1];
    den_w   = DVW'(den_q);
    den_abs = den_neg ? -den_w : den_w;
    divisor = DVW'(den_abs) << 1;
    d_ext   = cmd_i.div_sel_y ? DIFW'(dy_q) : DIFW'(dx_q);
    d_adj   = den_neg ? -d_ext : d_ext;
    n_c     = (NW'(d_adj) <<< ROUND_SHIFT) + NW'($signed({1'b0, den_abs}));
    n_neg   = n_c[NW-1];
    n_mag   = n_neg ? NW'(-n_c) : NW'(n_c);
  end

  logic [NW-1:0] quo;
  logic          rem_nz;
  logic          div_done;
  logic          n_neg_q;
  logic          sel_y_q;

  hpf_divider #(
    .NUM_W (NW),
    .DEN_W (DVW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_i    (n_mag),
    .den_i    (divisor),
    .quo_o    (quo),
    .rem_nz_o (rem_nz),
    .done_o   (div_done)
  );

  assign st_o.div_done = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      n_neg_q <= n_neg;
      sel_y_q <= cmd_i.div_sel_y;
    end
  end

  // floor quotient, add centre offset, saturate to the map
  logic signed [NW:0]   r_c;
  logic signed [TW-1:0] base, total, hi, pos_sat;

  always_comb begin
    r_c = n_neg_q ? -($signed({1'b0, quo}) + $signed((NW+1)'(rem_nz)))
                  : $signed({1'b0, quo});
    if (sel_y_q) begin
      base = $signed(TW'({cy_q, {FRAC_BITS{1'b0}}}));
      hi   = $signed(TW'({h_dim - HW'(1), {FRAC_BITS{1'b0}}}));
    end else begin
      base = $signed(TW'({cx_q, {FRAC_BITS{1'b0}}}));
      hi   = $signed(TW'({w_dim - DIMW'(1), {FRAC_BITS{1'b0}}}));
    end
    total = TW'(r_c) + base;
    if (total < 0)       pos_sat = '0;
    else if (total > hi) pos_sat = hi;
    else                 pos_sat = total;
  end

  logic [POS_W-1:0] x_res_q, y_res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_x) x_res_q <= pos_sat[POS_W-1:0];
    if (cmd_i.latch_y) y_res_q <= pos_sat[POS_W-1:0];
  end

  // output register
  logic                 res_valid_q;
  logic                 kind_q, zw_q, last_q;
  logic [POS_W-1:0]     xo_q, yo_q;
  logic signed [SB-1:0] so_q;
  logic [COUNT_W-1:0]   co_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_peak || cmd_i.load_sum) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_peak) begin
      kind_q <= KIND_PEAK;
      xo_q   <= zero_q ? POS_W'({cx_q, {FRAC_BITS{1'b0}}}) : x_res_q;
      yo_q   <= zero_q ? POS_W'({cy_q, {FRAC_BITS{1'b0}}}) : y_res_q;
      so_q   <= score_q;
      co_q   <= COUNT_W'(cnt_peak_q);
      zw_q   <= zero_q;
      last_q <= 1'b0;
    end else if (cmd_i.load_sum) begin
      kind_q <= KIND_SUMMARY;
      xo_q   <= '0;
      yo_q   <= '0;
      so_q   <= '0;
      co_q   <= COUNT_W'(cnt_sum_q);
      zw_q   <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign st_o.out_free   = !res_valid_q || res_o.ready;
  assign res_o.valid       = res_valid_q;
  assign res_o.kind        = kind_q;
  assign res_o.x_pos       = xo_q;
  assign res_o.y_pos       = yo_q;
  assign res_o.score       = so_q;
  assign res_o.peak_count  = co_q;
  assign res_o.zero_weight = zw_q;
  assign res_o.last        = last_q;

  // checks
  `HPF_ASSERT_IMP(a_peak_limit, 1'b1, PKW'(peaks_q) <= PKW'(MAX_PEAKS), "peak count over limit")
  `HPF_ASSERT_IMP(a_no_overwrite, cmd_i.load_peak || cmd_i.load_sum,
                  !res_valid_q || res_o.ready, "result register overwritten")
  `HPF_ASSERT_NEXT(a_map_restart, cmd_i.eval && end_hit,
                   col_q == '0 && row_q == '0 && peaks_q == '0, "map end did not restart")
endmodule

>>> hdl/heatmap_peak_finder_unit.sv
// 3x3 peak finder over a heatmap that streams in raster order.
// in_i carries one signed sample per word; res_o carries peak reports and one
// end-of-map summary word (kind = 1, last = 1) after the last sample of a map.
// cfg_i writes threshold (index 0), map width (1) and map height (2); it is
// always ready and should only be used while no item is in flight.
// Each sample passes capture with line buffer read, window shift, evaluate
// and decide before the next sample is accepted. A sample that completes a
// peak with a nonzero neighbour weight sum adds two passes of the bit-serial
// divider; every peak report and every summary adds a load of the result
// register.
// The peak for pixel (y, x) is reported after the sample at (y+1, x+1).
// After reset the two line buffers are cleared one address per cycle, over
// all MAX_WIDTH addresses; no sample is taken meanwhile.
// A result waits in the output register while the receiver stalls; the
// block stops before loading the next result until that word is taken.
module heatmap_peak_finder_unit import hpf_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_PEAKS   = MAX_PEAKS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hpf_sample_if.sink   in_i,
  hpf_result_if.source res_o,
  hpf_cfg_if.sink      cfg_i
);
  hpf_cmd_t    cmd;
  hpf_status_t status;
  logic        in_ready;

  assign in_i.ready = in_ready;

  hpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .st_i       (status),
    .cmd_o      (cmd)
  );

  hpf_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_PEAKS   (MAX_PEAKS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (in_i.sample),
    .cmd_i    (cmd),
    .st_o     (status),
    .cfg_i    (cfg_i),
    .res_o    (res_o)
  );
endmodule

>>> test/tb_peak_checker.sv
`timescale 1ns / 1ps

// watches the sample, config and result channels, predicts each result word
// and compares it with what the block delivers
module tb_peak_checker import hpf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  hpf_sample_if smp_i,
  hpf_result_if res_i,
  hpf_cfg_if    cfg_i,
  output int    fail_cnt_o,
  output int    pending_o
);

  localparam int LINE_W = 512;
  localparam int PEAK_LIMIT = 16;

  typedef struct packed {
    logic                 kind;
    logic [POS_W-1:0]     x_pos;
    logic [POS_W-1:0]     y_pos;
    logic signed [15:0]   score;
    logic [COUNT_W-1:0]   peak_count;
    logic                 zero_weight;
    logic                 last;
  } peak_word_t;

  peak_word_t peak_words_q[$];

  // predictor copy of the configuration and the state
  logic signed [15:0] thr_q;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic signed [15:0] lines_q[2*LINE_W];
  logic signed [15:0] win_q[9];
  logic [8:0]         col_q;
  logic [8:0]         row_q;
  logic [4:0]         found_q;
  int                 fails;

  function automatic int clamp_size(input logic [DIM_W-1:0] v);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > 512) return 512;
    return int'(v);
  endfunction

  // rounded quotient, ties away from zero, saturated to 0 .. hi
  function automatic logic [POS_W-1:0] round_div(input longint num, input longint den,
                                                 input longint hi);
    longint an, ad, q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    if ((num < 0) != (den < 0)) return '0;
    if (q > hi) q = hi;
    return q[POS_W-1:0];
  endfunction

  // advance the window by one sample and queue the words it causes
  task automatic predict_sample(input logic signed [15:0] s);
    int         w, h, c, k;
    logic       is_peak;
    longint     cx, cy, xn, yn, den, vk;
    peak_word_t pw;
    w = clamp_size(width_q);
    h = clamp_size(height_q);
    c = int'(col_q) % LINE_W;
    for (k = 0; k < 3; k++) begin
      win_q[3*k]   = win_q[3*k+1];
      win_q[3*k+1] = win_q[3*k+2];
    end
    win_q[2] = lines_q[c];
    win_q[5] = lines_q[LINE_W + c];
    win_q[8] = s;
    lines_q[c] = lines_q[LINE_W + c];
    lines_q[LINE_W + c] = s;

    if (row_q >= 2 && col_q >= 2 && found_q < PEAK_LIMIT) begin
      is_peak = (win_q[4] > thr_q);
      for (k = 0; k < 9; k++)
        if (k != 4 && !(win_q[4] > win_q[k])) is_peak = 1'b0;
      if (is_peak) begin
        cx = longint'(col_q) - 1;
        cy = longint'(row_q) - 1;
        xn = 0; yn = 0; den = 0;
        for (k = 0; k < 9; k++) begin
          if (k != 4) begin
            vk = longint'(win_q[k]);
            xn += vk * (cx - 1 + k % 3) * 64;
            yn += vk * (cy - 1 + k / 3) * 64;
            den += vk;
          end
        end
        pw = '0;
        pw.kind = KIND_PEAK;
        pw.score = win_q[4];
        if (den == 0) begin
          pw.zero_weight = 1'b1;
          pw.x_pos = POS_W'(cx * 64);
          pw.y_pos = POS_W'(cy * 64);
        end else begin
          pw.x_pos = round_div(xn, den, longint'(w - 1) * 64);
          pw.y_pos = round_div(yn, den, longint'(h - 1) * 64);
        end
        found_q = found_q + 1;
        pw.peak_count = found_q;
        peak_words_q = {peak_words_q, pw};
      end
    end

    if (int'(col_q) + 1 >= w) begin
      col_q = '0;
      if (int'(row_q) + 1 >= h) begin
        pw = '0;
        pw.kind = KIND_SUMMARY;
        pw.peak_count = found_q;
        pw.last = 1'b1;
        peak_words_q = {peak_words_q, pw};
        row_q = '0;
        found_q = '0;
      end else begin
        row_q = row_q + 1;
      end
    end else begin
      col_q = col_q + 1;
    end
  endtask

  // one failure, reported for the first ten only
  task automatic note_fail(input string what, input peak_word_t exp_w, input peak_word_t got_w);
    fails++;
    if (fails <= 10)
      $display("%t %s exp kind=%0d x=%0d y=%0d score=%0d cnt=%0d zw=%0d last=%0d",
               $realtime, what, exp_w.kind, exp_w.x_pos, exp_w.y_pos, exp_w.score,
               exp_w.peak_count, exp_w.zero_weight, exp_w.last,
               "  got kind=%0d x=%0d y=%0d score=%0d cnt=%0d zw=%0d last=%0d",
               got_w.kind, got_w.x_pos, got_w.y_pos, got_w.score,
               got_w.peak_count, got_w.zero_weight, got_w.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    peak_word_t got_w, exp_w;
    if (!rst_ni) begin
      thr_q = THRESH_RESET;
      width_q = DIM_RESET;
      height_q = DIM_RESET;
      for (int i = 0; i < 2 * LINE_W; i++) lines_q[i] = '0;
      for (int i = 0; i < 9; i++) win_q[i] = '0;
      col_q = '0;
      row_q = '0;
      found_q = '0;
      fails = 0;
      peak_words_q.delete();
    end else begin
      // compare the delivered result word
      if (res_i.valid && res_i.ready) begin
        got_w.kind = res_i.kind;
        got_w.x_pos = res_i.x_pos;
        got_w.y_pos = res_i.y_pos;
        got_w.score = res_i.score;
        got_w.peak_count = res_i.peak_count;
        got_w.zero_weight = res_i.zero_weight;
        got_w.last = res_i.last;
        if (peak_words_q.size() == 0) begin
          note_fail("unexpected word", '0, got_w);
        end else begin
          exp_w = peak_words_q.pop_front();
          if (got_w.kind !== exp_w.kind || got_w.x_pos !== exp_w.x_pos ||
              got_w.y_pos !== exp_w.y_pos || got_w.score !== exp_w.score ||
              got_w.peak_count !== exp_w.peak_count ||
              got_w.zero_weight !== exp_w.zero_weight || got_w.last !== exp_w.last)
            note_fail("word mismatch", exp_w, got_w);
        end
      end
      // register writes
      if (cfg_i.valid && cfg_i.ready) begin
        case (hpf_reg_e'(cfg_i.index))
          REG_THRESHOLD:  thr_q = cfg_i.data;
          REG_MAP_WIDTH:  width_q = cfg_i.data[DIM_W-1:0];
          REG_MAP_HEIGHT: height_q = cfg_i.data[DIM_W-1:0];
          default: ;
        endcase
      end
      // accepted sample
      if (smp_i.valid && smp_i.ready) predict_sample(smp_i.sample);
    end
    fail_cnt_o = fails;
    pending_o = peak_words_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hpf_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RAND_ITEMS = 270;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  int   idle_cycles = 0;
  bit   send_fast = 1'b0;
  bit   recv_fast = 1'b0;
  bit   hold_req = 1'b0;

  hpf_sample_if smp_if ();
  hpf_result_if res_if ();
  hpf_cfg_if    cfg_if ();

  heatmap_peak_finder_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  tb_peak_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp_if),
    .res_i      (res_if),
    .cfg_i      (cfg_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    res_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_THRESHOLD;
    cfg_if.data = '0;
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("heatmap_peak_finder_unit: mismatch");
      $finish;
    end
  end

  // receiver: random stalls after each word, one long hold-off on request
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        w = recv_fast ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 19) == 0) recv_fast = ~recv_fast;
        if (hold_req) begin
          w = 300;
          hold_req = 1'b0;
        end
        if (w > 0) begin
          res_if.ready <= 1'b0;
          repeat (w) @(posedge clk_i);
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // offer one sample, holding valid across back-to-back words
  task automatic send_sample(input logic signed [15:0] s);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.sample <= s;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
  endtask

  // wait for every word, let the block settle, then write all three registers
  task automatic program_regs(input logic [15:0] thr, input logic [15:0] wd,
                              input logic [15:0] ht);
    smp_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    for (int r = 0; r < 3; r++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= (r == 0) ? REG_THRESHOLD : (r == 1) ? REG_MAP_WIDTH : REG_MAP_HEIGHT;
      cfg_if.data <= (r == 0) ? thr : (r == 1) ? wd : ht;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // background noise with spikes and the odd full-range or extreme value
  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($signed($urandom_range(0, 400)) - 200);
    if (r < 85) return 16'($urandom_range(500, 32767));
    if (r < 95) return 16'($urandom);
    return (r < 97) ? 16'sh8000 : 16'sh7fff;
  endfunction

  task automatic send_random_map(input int wd, input int ht);
    for (int i = 0; i < wd * ht; i++) send_sample(pick_sample());
  endtask

  // 3x3 map given row by row
  task automatic send_tile(input logic signed [15:0] t[9]);
    for (int i = 0; i < 9; i++) send_sample(t[i]);
  endtask

  initial begin
    int sent;
    int wd, ht;
    logic signed [15:0] tile[9];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero neighbour weight, then centroid saturating low and high
    program_regs(16'd0, 16'd3, 16'd3);
    tile = '{0, 0, 0, 0, 1000, 0, 0, 0, 0};
    send_tile(tile);
    tile = '{100, 0, -99, 100, 1000, -99, 100, 0, -99};
    send_tile(tile);
    tile = '{-99, 0, 100, -99, 1000, 100, -99, 0, 100};
    send_tile(tile);
    tile = '{-32768, -32768, -32768, -32768, 32767, -32768, -32768, -32768, -32768};
    send_tile(tile);

    // threshold extremes
    program_regs(16'h7fff, 16'd4, 16'd4);
    send_random_map(4, 4);
    program_regs(16'h8000, 16'hfc04, 16'd3);
    tile = '{-32768, -32768, -32768, -32768, -32767, -32768, -32768, -32768, -32768};
    send_tile(tile);
    send_random_map(4, 3);

    // peak limit: dense spike grid
    program_regs(16'd410, 16'd20, 16'd12);
    for (int y = 0; y < 12; y++)
      for (int x = 0; x < 20; x++)
        send_sample((x % 2 == 1 && y % 2 == 1) ? 16'(5000 + $urandom_range(0, 20000))
                                               : 16'($urandom_range(0, 300)));

    // out-of-range sizes clamped: one full-width row, then the map ends 3 wide
    program_regs(16'd200, 16'd1023, 16'd1);
    send_random_map(512, 1);
    program_regs(16'd300, 16'd0, 16'd1);
    send_random_map(3, 2);

    // random maps, small sizes; one long receiver hold-off early on
    sent = 0;
    hold_req = 1'b1;
    while (sent < RAND_ITEMS) begin
      wd = $urandom_range(3, 12);
      ht = $urandom_range(3, 10);
      case ($urandom_range(0, 2))
        0: program_regs(16'($urandom_range(0, 2000)), 16'(wd), 16'(ht));
        1: program_regs(16'd410, 16'(wd), 16'(ht));
        default: program_regs(16'($urandom), 16'(wd), 16'(ht));
      endcase
      send_fast = ($urandom_range(0, 3) == 0);
      send_random_map(wd, ht);
      sent += wd * ht;
    end
    smp_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("heatmap_peak_finder_unit: match");
    end else begin
      $display("heatmap_peak_finder_unit: mismatch");
    end
    $finish;
  end

endmodule
